// ----- hw/rtl/adc_ladder_button_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ladder keypad classifier
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ADC_LADDER_BUTTON_CLASSIFIER_DEFINES_SVH
`define ADC_LADDER_BUTTON_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, ignored while reset is low
`define ALBC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define ALBC_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ALBC_ASSERT(name, clk, rst_n, prop, msg)
`define ALBC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/albc_pkg.sv -----
// ----------------------------------------------------------------------------
// albc_pkg
// Shared types and constants of the ladder keypad classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package albc_pkg;

	// Field widths
	localparam int CENTRE_COUNT = 8;
	localparam int CENTRE_W     = 12;
	localparam int BTN_W        = 4;
	localparam int WIN_W        = 11;
	localparam int MS_W         = 16;
	localparam int TIME_W       = 32;
	localparam int EV_W         = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int OUT_DATA_W   = 8;

	// Two's complement -1 marks "no button"
	localparam logic [BTN_W-1:0] BTN_NONE = '1;

	// Ladder centre values, button 0 first
	localparam logic [CENTRE_W-1:0] CENTRES [CENTRE_COUNT] = '{
		12'd413, 12'd823, 12'd1365, 12'd1820,
		12'd2258, 12'd2705, 12'd3291, 12'd3979
	};

	typedef enum logic [EV_W-1:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_LONG     = 3'd2,
		EV_SHORT    = 3'd3,
		EV_RELEASED = 3'd4
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW      = 2'd0,
		REG_DEBOUNCE    = 2'd1,
		REG_SHORT_CLICK = 2'd2,
		REG_LONG_PRESS  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_half_width;
		logic [MS_W-1:0]  debounce_ms;
		logic [MS_W-1:0]  short_click_ms;
		logic [MS_W-1:0]  long_press_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		window_half_width: 11'd100,
		debounce_ms:       16'd40,
		short_click_ms:    16'd300,
		long_press_ms:     16'd1000
	};

	typedef struct packed {
		logic [BTN_W-1:0] key_id;
		event_t           event_code;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/albc_match.sv -----
// ----------------------------------------------------------------------------
// albc_match
// Window compare of one sample against the ladder centres; lowest hit wins.
// ----------------------------------------------------------------------------
`default_nettype none

module albc_match import albc_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int NUM_BUTTONS = 8
) (
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [WIN_W-1:0]       window,
	output logic      [BTN_W-1:0]       button
);

	localparam int N_ACTIVE = (NUM_BUTTONS < CENTRE_COUNT) ? NUM_BUTTONS : CENTRE_COUNT;
	localparam int CMP_W    = ((SAMPLE_BITS > CENTRE_W) ? SAMPLE_BITS : CENTRE_W) + 2;

	logic [CMP_W-1:0]    sample_w;
	logic [CMP_W-1:0]    window_w;
	logic [N_ACTIVE-1:0] hit;

	assign sample_w = CMP_W'(sample);
	assign window_w = CMP_W'(window);

	// Test c - w <= s <= c + w without going negative: s + w >= c and s <= c + w
	for (genvar g = 0; g < N_ACTIVE; g++) begin : g_win
		assign hit[g] = (sample_w + window_w >= CMP_W'(CENTRES[g])) &&
		                (sample_w <= CMP_W'(CENTRES[g]) + window_w);
	end

	// Pick the lowest-numbered hit
	always_comb begin
		button = BTN_NONE;
		for (int i = N_ACTIVE - 1; i >= 0; i--) begin
			if (hit[i]) begin
				button = BTN_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/albc_track.sv -----
// ----------------------------------------------------------------------------
// albc_track
// Debounce, press timing and event decision; holds the per-poll state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_ladder_button_classifier_defines.svh"

module albc_track import albc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [BTN_W-1:0]  match_button,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire cfg_t              cfg,
	output result_t                res
);

	logic [BTN_W-1:0]  debounce_button_q;
	logic [TIME_W-1:0] debounce_start_q;
	logic [BTN_W-1:0]  timing_button_q;
	logic [TIME_W-1:0] press_start_q;
	logic [TIME_W-1:0] prior_duration_q;
	event_t            prior_event_q;
	logic [BTN_W-1:0]  prior_button_q;

	logic [BTN_W-1:0]  debounce_button_d;
	logic [TIME_W-1:0] debounce_start_d;
	logic [TIME_W-1:0] press_start_d;
	logic [TIME_W-1:0] duration;
	logic [TIME_W-1:0] db_elapsed;
	logic [BTN_W-1:0]  btn;
	logic [BTN_W-1:0]  btn_out;
	logic              matched;
	event_t            ev;

	assign matched = (match_button != BTN_NONE);

	// Debounce: restart the timer on a new matched button, leave it alone on no match
	always_comb begin
		debounce_button_d = debounce_button_q;
		debounce_start_d  = debounce_start_q;
		btn               = BTN_NONE;
		if (matched) begin
			debounce_button_d = match_button;
			if (debounce_button_q != match_button) begin
				debounce_start_d = now_ms;
			end
		end
		db_elapsed = now_ms - debounce_start_d;
		if (matched && (db_elapsed > TIME_W'(cfg.debounce_ms))) begin
			btn = match_button;
		end
	end

	// Press timing: restart on a change or while nothing is pressed
	always_comb begin
		press_start_d = press_start_q;
		if ((timing_button_q != btn) || (btn == BTN_NONE)) begin
			press_start_d = now_ms;
		end
		duration = now_ms - press_start_d;
	end

	// Event decision, each rule refining the one before
	always_comb begin
		ev      = (btn != BTN_NONE) ? EV_PRESSED : EV_RELEASED;
		btn_out = btn;
		if ((prior_event_q == EV_PRESSED) && (ev == EV_RELEASED) &&
		    (prior_duration_q < TIME_W'(cfg.short_click_ms))) begin
			ev      = EV_SHORT;
			btn_out = prior_button_q;
		end
		if ((ev == EV_PRESSED) && (duration > TIME_W'(cfg.long_press_ms))) begin
			ev = EV_LONG;
		end
		if ((ev == EV_RELEASED) && (prior_event_q == EV_RELEASED)) begin
			ev = EV_NONE;
		end
		if ((prior_event_q == EV_NONE) && (ev == EV_RELEASED)) begin
			ev = EV_NONE;
		end
	end

	// Report the previous poll's button with this poll's event
	assign res.key_id     = prior_button_q;
	assign res.event_code = ev;

	// Advance the state once per poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_button_q <= BTN_NONE;
			debounce_start_q  <= '0;
			timing_button_q   <= BTN_NONE;
			press_start_q     <= '0;
			prior_duration_q  <= '0;
			prior_event_q     <= EV_NONE;
			prior_button_q    <= BTN_NONE;
		end else if (en) begin
			debounce_button_q <= debounce_button_d;
			debounce_start_q  <= debounce_start_d;
			timing_button_q   <= btn;
			press_start_q     <= press_start_d;
			prior_duration_q  <= duration;
			prior_event_q     <= ev;
			prior_button_q    <= btn_out;
		end
	end

	`ALBC_ASSERT(a_short_after_press, clk, arst_n, (en && (ev == EV_SHORT)) |-> (prior_event_q == EV_PRESSED), "short click without a press before it")
	`ALBC_ASSERT(a_long_has_button, clk, arst_n, (en && (ev == EV_LONG)) |=> (prior_button_q != BTN_NONE), "long press recorded with no button")
	`ALBC_ASSERT(a_state_holds, clk, arst_n, !en |=> ($stable(prior_event_q) && $stable(prior_button_q)), "tracker state moved without a poll")

endmodule

`default_nettype wire

// ----- hw/rtl/adc_ladder_button_classifier.sv -----
// ----------------------------------------------------------------------------
// adc_ladder_button_classifier
// Resistor-ladder keypad decoder with debounce, press timing and events.
// ----------------------------------------------------------------------------
// Takes one poll (ADC sample plus millisecond timestamp) per clock cycle
// while the output is not stalled, and returns exactly one result per poll:
// the button decided on the previous poll and the event worked out on this
// one. A poll passes the input register, the match register and the result
// register before its result appears on the output; the debounce and
// press-timing state is updated once per poll. Each stage holds when the
// stage after it is full and stalled, so up to two more polls transfer in
// while a result waits before the input stalls. Configuration registers may
// be rewritten only while no poll is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_ladder_button_classifier_defines.svh"

module adc_ladder_button_classifier import albc_pkg::*; #(
	parameter int NUM_BUTTONS = 8,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// Poll input
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// s_tdata, low bit up: adc_sample, now_ms, zero fill
	input  wire logic [((SAMPLE_BITS + TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
	// Result output
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// m_tdata, low bit up: key_id, event_code, zero fill
	output logic [OUT_DATA_W-1:0]     m_tdata
);

	cfg_t                    cfg_q;

	logic                    valid_s1;
	logic [SAMPLE_BITS-1:0]  sample_s1;
	logic [TIME_W-1:0]       now_s1;

	logic                    valid_s2;
	logic [BTN_W-1:0]        button_s2;
	logic [TIME_W-1:0]       now_s2;

	logic                    out_valid_q;
	result_t                 result_q;

	logic                    ready_out;
	logic                    ready_s2;
	logic                    ready_s1;
	logic [BTN_W-1:0]        match_button;
	result_t                 track_res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW:      cfg_q.window_half_width <= cfg_data[WIN_W-1:0];
				REG_DEBOUNCE:    cfg_q.debounce_ms       <= cfg_data[MS_W-1:0];
				REG_SHORT_CLICK: cfg_q.short_click_ms    <= cfg_data[MS_W-1:0];
				REG_LONG_PRESS:  cfg_q.long_press_ms     <= cfg_data[MS_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// Per-stage ready: a stage moves when it is empty or the next one moves
	assign ready_out = !out_valid_q || m_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && ready_s1) begin
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
			now_s1    <= s_tdata[SAMPLE_BITS +: TIME_W];
		end
	end

	albc_match #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_match (
		.sample (sample_s1),
		.window (cfg_q.window_half_width),
		.button (match_button)
	);

	// Match register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			button_s2 <= match_button;
			now_s2    <= now_s1;
		end
	end

	albc_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (valid_s2 && ready_out),
		.match_button (button_s2),
		.now_ms       (now_s2),
		.cfg          (cfg_q),
		.res          (track_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_out) begin
			result_q <= track_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - BTN_W - EV_W){1'b0}}, result_q.event_code,
	                   result_q.key_id};

	`ALBC_ASSERT(a_result_loaded, clk, arst_n, (valid_s2 && ready_out) |=> m_tvalid, "poll lost")
	`ALBC_ASSERT(a_match_held, clk, arst_n, (valid_s2 && !ready_out) |=> (valid_s2 && $stable(button_s2)), "stalled poll lost")
	`ALBC_ASSERT_ALWAYS(a_quiet_in_reset, clk, !arst_n |=> !m_tvalid, "result valid after reset")

endmodule

`default_nettype wire
